[sv/hrp_pkg.sv]
package hrp_pkg;

	// Transfer payloads
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] kind;
		logic       is_host;
		logic       pair_valid;
		logic [2:0] method;
		logic       method_valid;
		logic       headers_done;
		logic       last_out;
	} out_item_t;

	// Request-line method tracker state
	typedef struct packed {
		logic [4:0] candidates;
		logic [2:0] code;
	} method_state_t;

	// Parser phases
	localparam logic [2:0] PH_REQ   = 3'd0;
	localparam logic [2:0] PH_NAME  = 3'd1;
	localparam logic [2:0] PH_SKIP  = 3'd2;
	localparam logic [2:0] PH_VALUE = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd5;

	// Result kinds
	localparam logic [2:0] K_REQ   = 3'd0;
	localparam logic [2:0] K_NAME  = 3'd1;
	localparam logic [2:0] K_SKIP  = 3'd2;
	localparam logic [2:0] K_VALUE = 3'd3;
	localparam logic [2:0] K_EOL   = 3'd4;
	localparam logic [2:0] K_AFTER = 3'd5;

	// Method codes
	localparam logic [2:0] MTH_NONE    = 3'd0;
	localparam logic [2:0] MTH_GET     = 3'd1;
	localparam logic [2:0] MTH_POST    = 3'd2;
	localparam logic [2:0] MTH_PUT     = 3'd3;
	localparam logic [2:0] MTH_HEAD    = 3'd4;
	localparam logic [2:0] MTH_CONNECT = 3'd5;

	localparam int NUM_METHODS = 5;
	localparam logic [4:0] ALL_ALIVE = 5'b11111;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic [3:0] LINE_POS_MAX = 4'd15;
	localparam logic [2:0] NAME_LEN_MAX = 3'd7;
	localparam logic [2:0] HOST_LEN     = 3'd4;

	// Method text, left aligned, space terminated
	function automatic logic [7:0] method_char(input logic [2:0] k, input logic [2:0] pos);
		logic [63:0] txt;
		logic [5:0]  ofs;
		unique case (k)
			3'd0: txt = {"GET ", 32'h0};
			3'd1: txt = {"POST ", 24'h0};
			3'd2: txt = {"PUT ", 32'h0};
			3'd3: txt = {"HEAD ", 24'h0};
			default: txt = "CONNECT ";
		endcase
		ofs = {3'd7 - pos, 3'b000};
		return txt[ofs +: 8];
	endfunction

	function automatic logic [3:0] method_len(input logic [2:0] k);
		logic [3:0] len;
		unique case (k)
			3'd0: len = 4'd4;
			3'd1: len = 4'd5;
			3'd2: len = 4'd4;
			3'd3: len = 4'd5;
			default: len = 4'd8;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] host_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = "h";
			2'd1: c = "o";
			2'd2: c = "s";
			default: c = "t";
		endcase
		return c;
	endfunction

endpackage

[sv/http_request_header_parser_unit.sv]
// HTTP/1.1 request header parser. One request byte goes in per transfer on the
// text channel and exactly one tag item comes out per byte on the tag channel,
// in order. The tag gives the byte (lowercased inside header names), its role
// (request line, name, colon/skip, value, line end, after headers), whether the
// current header name is "host", whether a finished header line had both a
// non-empty name and value, and the request method (GET, POST, PUT, HEAD,
// CONNECT) once the request line has ended. Setting last on the final byte of
// a request returns the parser to the request-line phase for the next request.
// Throughput is one byte per clock while the tag side does not stall: the per-byte
// parse is one short step of logic between the input register and the result
// register, and the parse state updates as a byte moves from one to the other.
// A byte goes from its text transfer into the input register and then into the
// result register, where its tag is valid; a tag-side stall can hold it back. The
// input side stalls only when both registers are full and the tag side is stalled.
module http_request_header_parser_unit import hrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      text_valid,
	output logic      text_stall,
	input  in_item_t  text_item,
	output logic      tag_valid,
	input  logic      tag_stall,
	output out_item_t tag_item
);

	// input register
	in_item_t  item_s1;
	logic      valid_s1;
	// result register
	out_item_t item_s2;
	logic      valid_s2;

	out_item_t res;
	logic      adv;    // byte moves s1 -> s2, parse state steps
	logic      take;   // text transfer

	assign adv        = valid_s1 && (!valid_s2 || !tag_stall);
	assign text_stall = valid_s1 && valid_s2 && tag_stall;
	assign take       = text_valid && !text_stall;

	hrp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= text_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!tag_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			item_s2 <= res;
	end

	assign tag_valid = valid_s2;
	assign tag_item  = item_s2;

	// stall only with a byte waiting in the input register
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// pair flag only on a line end
	a_pair_on_eol: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_valid && tag_item.pair_valid) |-> (tag_item.kind == K_EOL))
		else $error("pair_valid outside line end");

	// header section cannot end before the request line
	a_done_after_method: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_valid && tag_item.headers_done) |-> tag_item.method_valid)
		else $error("headers_done without method_valid");

	// host flag only after the colon
	a_host_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_valid && tag_item.is_host) |->
			(tag_item.kind == K_SKIP || tag_item.kind == K_VALUE ||
			 tag_item.kind == K_EOL))
		else $error("is_host on a name or request byte");

endmodule

[sv/hrp_method.sv]
module hrp_method import hrp_pkg::*; (
	input  logic [7:0]    data_byte,
	input  logic [3:0]    line_pos,
	input  method_state_t cur,
	output method_state_t nxt
);

	// All five candidates compared in parallel; a later match wins the code.
	always_comb begin
		nxt = cur;
		for (int k = 0; k < NUM_METHODS; k++) begin
			if (cur.candidates[k] && line_pos < method_len(3'(k))) begin
				if (data_byte == method_char(3'(k), line_pos[2:0])) begin
					if (line_pos == method_len(3'(k)) - 4'd1)
						nxt.code = 3'(k + 1);
				end else begin
					nxt.candidates[k] = 1'b0;
				end
			end
		end
	end

endmodule

[sv/hrp_parse.sv]
module hrp_parse import hrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	output out_item_t res
);

	logic [2:0]    phase_q, phase_d;
	logic [3:0]    line_pos_q, line_pos_d;
	method_state_t mth_q, mth_d, mth_upd;
	logic [2:0]    name_len_q, name_len_d;
	logic          host_q, host_d;
	logic          seen_q, seen_d;

	logic [7:0] b, lc;
	logic       nl, cur_host;

	assign b        = item.data_byte;
	assign nl       = (b == CH_NL);
	assign lc       = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
	assign cur_host = host_q && (name_len_q == HOST_LEN);

	hrp_method u_method (
		.data_byte (b),
		.line_pos  (line_pos_q),
		.cur       (mth_q),
		.nxt       (mth_upd)
	);

	always_comb begin
		phase_d    = phase_q;
		line_pos_d = line_pos_q;
		mth_d      = mth_q;
		name_len_d = name_len_q;
		host_d     = host_q;
		seen_d     = seen_q;

		res            = '0;
		res.out_byte   = b;
		res.kind       = K_AFTER;
		res.last_out   = item.last;

		unique case (phase_q)
			PH_REQ: begin
				if (nl) begin
					res.kind   = K_EOL;
					phase_d    = PH_NAME;
					line_pos_d = '0;
					name_len_d = '0;
					host_d     = 1'b1;
					seen_d     = 1'b0;
				end else begin
					res.kind = K_REQ;
					mth_d    = mth_upd;
					if (line_pos_q < LINE_POS_MAX)
						line_pos_d = line_pos_q + 4'd1;
				end
			end
			PH_NAME: begin
				if (nl) begin
					res.kind = K_EOL;
					if (name_len_q == '0)
						phase_d = PH_DONE;
					name_len_d = '0;
					host_d     = 1'b1;
					seen_d     = 1'b0;
				end else if (b == CH_COLON) begin
					res.kind = K_SKIP;
					phase_d  = PH_SKIP;
				end else begin
					res.kind     = K_NAME;
					res.out_byte = lc;
					if (name_len_q < HOST_LEN) begin
						if (lc != host_char(name_len_q[1:0]))
							host_d = 1'b0;
					end else begin
						host_d = 1'b0;
					end
					if (name_len_q < NAME_LEN_MAX)
						name_len_d = name_len_q + 3'd1;
				end
			end
			PH_SKIP: begin
				res.is_host = cur_host;
				if (nl) begin
					res.kind   = K_EOL;
					phase_d    = PH_NAME;
					name_len_d = '0;
					host_d     = 1'b1;
					seen_d     = 1'b0;
				end else begin
					res.kind = K_SKIP;
					phase_d  = PH_VALUE;
				end
			end
			PH_VALUE: begin
				res.is_host = cur_host;
				if (nl) begin
					res.kind       = K_EOL;
					res.pair_valid = (name_len_q != '0) && seen_q;
					phase_d        = PH_NAME;
					name_len_d     = '0;
					host_d         = 1'b1;
					seen_d         = 1'b0;
				end else begin
					res.kind = K_VALUE;
					seen_d   = 1'b1;
				end
			end
			default: begin
				res.kind = K_AFTER;
			end
		endcase

		res.method       = mth_d.code;
		res.method_valid = (phase_d != PH_REQ);
		res.headers_done = (phase_d == PH_DONE);

		// end of request: back to reset state
		if (item.last) begin
			phase_d    = PH_REQ;
			line_pos_d = '0;
			mth_d      = '{candidates: ALL_ALIVE, code: MTH_NONE};
			name_len_d = '0;
			host_d     = 1'b1;
			seen_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_REQ;
			line_pos_q <= '0;
			mth_q      <= '{candidates: ALL_ALIVE, code: MTH_NONE};
			name_len_q <= '0;
			host_q     <= 1'b1;
			seen_q     <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			line_pos_q <= line_pos_d;
			mth_q      <= mth_d;
			name_len_q <= name_len_d;
			host_q     <= host_d;
			seen_q     <= seen_d;
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

// Byte-stream check of the HTTP request header parser.
// A queue of request bytes feeds a valid/stall driver; every accepted byte runs
// through a local parse model whose tag is queued and compared, field by field,
// against the tags the block returns. Load runs through four phases:
// free-flowing, sparse sender, heavy back-pressure, and light mixed idling.
// Between phases the sender drains completely before it starts again.
module tb;
	import hrp_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int ITEMS_PER_PHASE = 325;

	// Request-line words, right aligned so the last char sits in the low byte
	localparam logic [63:0] REQ_WORD [NUM_METHODS] = '{"GET ", "POST ", "PUT ", "HEAD ",
		"CONNECT "};
	localparam logic [3:0]  REQ_LEN  [NUM_METHODS] = '{4'd4, 4'd5, 4'd4, 4'd5, 4'd8};
	localparam logic [31:0] HOST_WORD = "host";
	localparam logic [7:0]  CH_CR     = 8'h0D;
	localparam logic [7:0]  CH_SPACE  = 8'h20;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      text_valid = 1'b0;
	logic      text_stall;
	in_item_t  text_item = '0;
	logic      tag_valid;
	logic      tag_stall = 1'b0;
	out_item_t tag_item;

	http_request_header_parser_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_item  (text_item),
		.tag_valid  (tag_valid),
		.tag_stall  (tag_stall),
		.tag_item   (tag_item)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stimulus and scoreboard storage
	in_item_t   text_backlog[$];    // bytes waiting to be driven
	logic [7:0] staged[$];          // request under construction
	out_item_t  predicted_tags[$];  // tags owed by the block, oldest first

	int idle_pct  = 0;
	int stall_pct = 0;
	int errors    = 0;
	int cycles    = 0;

	// Coverage-ish tallies for the closing summary
	int         n_bytes = 0;
	int         n_tags = 0;
	int         n_pairs = 0;
	int         n_host = 0;
	int         n_after = 0;
	int         n_requests = 0;
	logic [5:0] methods_seen = '0;

	// ------------------------------------------------------------------
	// Parse model state
	// ------------------------------------------------------------------
	logic [2:0] pm_phase;
	logic [3:0] pm_line_pos;
	logic [4:0] pm_alive;
	logic [2:0] pm_method;
	logic [2:0] pm_name_len;
	logic       pm_host_ok;
	logic       pm_value_seen;

	function automatic void clear_header_line();
		pm_name_len   = '0;
		pm_host_ok    = 1'b1;
		pm_value_seen = 1'b0;
	endfunction

	function automatic void reset_parse_model();
		pm_phase    = PH_REQ;
		pm_line_pos = '0;
		pm_alive    = ALL_ALIVE;
		pm_method   = MTH_NONE;
		clear_header_line();
	endfunction

	// Advance the model by one byte and return the tag it must produce
	function automatic out_item_t predict_tag(input in_item_t it);
		out_item_t  r;
		logic [7:0] b;
		logic [7:0] want;
		logic       nl;
		logic       host_now;
		r          = '0;
		b          = it.data_byte;
		nl         = (b == CH_NL);
		r.out_byte = b;
		r.last_out = it.last;
		host_now   = pm_host_ok && (pm_name_len == HOST_LEN);
		case (pm_phase)
			PH_REQ: begin
				if (nl) begin
					r.kind      = K_EOL;
					pm_phase    = PH_NAME;
					pm_line_pos = '0;
					clear_header_line();
				end else begin
					r.kind = K_REQ;
					// every live candidate still inside its word compares this byte
					for (int k = 0; k < NUM_METHODS; k++) begin
						if (pm_alive[k] && pm_line_pos < REQ_LEN[k]) begin
							want = REQ_WORD[k][8 * (REQ_LEN[k] - 1 - pm_line_pos) +: 8];
							if (b == want) begin
								if (pm_line_pos == REQ_LEN[k] - 4'd1)
									pm_method = MTH_GET + 3'(k);
							end else begin
								pm_alive[k] = 1'b0;
							end
						end
					end
					if (pm_line_pos != LINE_POS_MAX)
						pm_line_pos = pm_line_pos + 4'd1;
				end
			end
			PH_NAME: begin
				if (nl) begin
					r.kind = K_EOL;
					if (pm_name_len == '0)
						pm_phase = PH_DONE;
					clear_header_line();
				end else if (b == CH_COLON) begin
					r.kind   = K_SKIP;
					pm_phase = PH_SKIP;
				end else begin
					r.kind = K_NAME;
					if (b >= CH_UP_A && b <= CH_UP_Z)
						r.out_byte = b + CASE_OFS;
					if (pm_name_len < HOST_LEN) begin
						if (r.out_byte != HOST_WORD[8 * (3 - pm_name_len) +: 8])
							pm_host_ok = 1'b0;
					end else begin
						pm_host_ok = 1'b0;
					end
					if (pm_name_len != NAME_LEN_MAX)
						pm_name_len = pm_name_len + 3'd1;
				end
			end
			PH_SKIP: begin
				r.is_host = host_now;
				if (nl) begin
					r.kind   = K_EOL;
					pm_phase = PH_NAME;
					clear_header_line();
				end else begin
					r.kind   = K_SKIP;
					pm_phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				r.is_host = host_now;
				if (nl) begin
					r.kind       = K_EOL;
					r.pair_valid = (pm_name_len != '0) && pm_value_seen;
					pm_phase     = PH_NAME;
					clear_header_line();
				end else begin
					r.kind        = K_VALUE;
					pm_value_seen = 1'b1;
				end
			end
			default: begin
				r.kind = K_AFTER;
			end
		endcase
		r.method       = pm_method;
		r.method_valid = (pm_phase != PH_REQ);
		r.headers_done = (pm_phase == PH_DONE);
		if (it.last)
			reset_parse_model();
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------
	function automatic logic [7:0] rand_plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_NL || b == CH_COLON);
		return b;
	endfunction

	function automatic logic [7:0] rand_name_byte();
		logic [7:0] b;
		case ($urandom_range(0, 3))
			0: b = CH_UP_A + 8'($urandom_range(0, 25));
			1: b = CH_UP_A + CASE_OFS + 8'($urandom_range(0, 25));
			default: b = rand_plain_byte();
		endcase
		return b;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		staged.push_back(b);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// Move the staged request to the backlog; a cut request ends early
	task automatic commit_staged(input bit cut);
		int       n;
		in_item_t it;
		n = staged.size();
		if (cut && n > 1)
			n = $urandom_range(1, n - 1);
		for (int i = 0; i < n; i++) begin
			it.data_byte = staged[i];
			it.last      = (i == n - 1);
			text_backlog.push_back(it);
		end
		staged.delete();
	endtask

	task automatic stage_header_line();
		int sel;
		case ($urandom_range(0, 9))
			0: push_text("Host");
			1: push_text("host");
			2: push_text("HOST");
			3: push_text("hosts");
			4: push_text("hst");
			5: push_text("Content-Length");
			6: ; // empty name, colon opens the line
			default: repeat ($urandom_range(1, 9)) push_byte(rand_name_byte());
		endcase
		sel = $urandom_range(0, 19);
		if (sel == 0) begin
			push_byte(CH_NL);          // line dies inside the name
		end else begin
			push_byte(CH_COLON);
			if (sel == 1) begin
				push_byte(CH_NL);      // line dies on the skipped byte
			end else begin
				push_byte(sel < 15 ? CH_SPACE : rand_plain_byte());
				repeat ($urandom_range(0, 6)) push_byte(rand_plain_byte());
				if ($urandom_range(0, 1))
					push_byte(CH_CR);
				push_byte(CH_NL);
			end
		end
	endtask

	task automatic add_request();
		string word;
		int    bad;
		int    sel;
		sel = $urandom_range(0, 5);
		case (sel)
			0: word = "GET ";
			1: word = "POST ";
			2: word = "PUT ";
			3: word = "HEAD ";
			4: word = "CONNECT ";
			default: word = "";
		endcase
		// one in five known methods gets a corrupted character
		bad = ($urandom_range(0, 4) == 0 && word.len() > 0) ?
			$urandom_range(0, word.len() - 1) : -1;
		if (word.len() == 0) begin
			repeat ($urandom_range(1, 4)) push_byte(rand_plain_byte());
		end else begin
			for (int i = 0; i < word.len(); i++)
				push_byte(i == bad ? rand_plain_byte() : word[i]);
		end
		// mostly short targets; a few run past the saturating line counter
		repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5))
			push_byte(8'($urandom_range(33, 126)));
		if ($urandom_range(0, 1))
			push_text(" HTTP/1.1\r");
		push_byte(CH_NL);
		repeat ($urandom_range(0, 4)) stage_header_line();
		push_byte(CH_NL);
		repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
		commit_staged($urandom_range(0, 9) == 0);
	endtask

	// Raw bytes; last lands at random, often mid-chunk or not at all
	task automatic add_noise();
		in_item_t it;
		repeat ($urandom_range(1, 6)) begin
			it.data_byte = 8'($urandom_range(0, 255));
			it.last      = ($urandom_range(0, 3) == 0);
			text_backlog.push_back(it);
		end
	endtask

	// HEAD method, colon-first line cut by a newline on the skip byte,
	// uppercase host with 0xFF and CR in the value, newline inside a name,
	// empty line, then a 0x00 after the headers carrying last.
	task automatic add_directed();
		push_text("HEAD \n:\nHOST: ");
		push_byte(8'hFF);
		push_text("\r\nab\n\n");
		push_byte(8'h00);
		commit_staged(1'b0);
	endtask

	// ------------------------------------------------------------------
	// Text driver: holds the payload while stalled, pulls from the backlog
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
			text_item  <= '0;
		end else begin
			if (text_valid && !text_stall) begin
				predicted_tags.push_back(predict_tag(text_item));
				n_bytes++;
				if (text_item.last)
					n_requests++;
			end
			if (!text_valid || !text_stall) begin
				if (text_backlog.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
					text_valid <= 1'b1;
					text_item  <= text_backlog.pop_front();
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// Tag-side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_stall <= 1'b0;
		else
			tag_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic check_field(input string fname, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			$error("%s: expected %0d, got %0d", fname, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Tag monitor
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t exp_tag;
		if (arst_n && tag_valid && !tag_stall) begin
			if (predicted_tags.size() == 0) begin
				errors++;
				$error("tag transfer with nothing outstanding: %h", tag_item);
			end else begin
				exp_tag = predicted_tags.pop_front();
				check_field("out_byte", exp_tag.out_byte, tag_item.out_byte);
				check_field("kind", exp_tag.kind, tag_item.kind);
				check_field("is_host", exp_tag.is_host, tag_item.is_host);
				check_field("pair_valid", exp_tag.pair_valid, tag_item.pair_valid);
				check_field("method", exp_tag.method, tag_item.method);
				check_field("method_valid", exp_tag.method_valid, tag_item.method_valid);
				check_field("headers_done", exp_tag.headers_done, tag_item.headers_done);
				check_field("last_out", exp_tag.last_out, tag_item.last_out);
				n_tags++;
				if (exp_tag.pair_valid)
					n_pairs++;
				if (exp_tag.is_host && exp_tag.kind == K_VALUE)
					n_host++;
				if (exp_tag.kind == K_AFTER)
					n_after++;
				if (exp_tag.method_valid)
					methods_seen[exp_tag.method] = 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$error("timeout: %0d tags still outstanding", predicted_tags.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequencing: reset, then four load phases each drained before the next
	// ------------------------------------------------------------------
	initial begin
		int target;
		reset_parse_model();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 70; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 70; end
				default: begin idle_pct = 9; stall_pct = 9; end
			endcase
			if (ph == 0)
				add_directed();
			target = text_backlog.size() + ITEMS_PER_PHASE;
			while (text_backlog.size() < target) begin
				if ($urandom_range(0, 99) < 85)
					add_request();
				else
					add_noise();
			end
			// sender holds off until every owed tag is back
			while (text_backlog.size() > 0 || text_valid || predicted_tags.size() > 0)
				@(negedge clk);
		end
		stall_pct = 0;
		repeat (10) @(negedge clk);
		$display("%0d bytes over %0d requests, %0d tags checked, %0d valid pairs,",
			n_bytes, n_requests, n_tags, n_pairs);
		$display("%0d host value bytes, %0d bytes after headers, method codes seen %b",
			n_host, n_after, methods_seen);
		if (errors == 0 && predicted_tags.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
